>>> hdl/ssc_pkg.sv
// Shared types and constants for the servo sweep controller.
// No dependencies; imported by every module of the block.
package ssc_pkg;

    localparam int ANGLE_MAX     = 180;
    localparam int ANGLE_HOME    = 90;
    localparam int DUTY_FULL     = 65535;
    localparam int PWM_PERIOD_US = 20000;
    localparam int SWEEP_BASE_MS = 105;
    localparam int SWEEP_STEP_MS = 10;

    localparam int SPEED_W     = 4;
    localparam int SPEED_MIN   = 1;
    localparam int SPEED_MAX   = 10;
    localparam int SPEED_RESET = 5;

    localparam int ANGLE_W   = 8;
    localparam int VALUE_W   = 8;
    localparam int DUTY_W    = 16;
    localparam int ELAPSED_W = 7;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ANGLE  = 2'd1,
        REQ_ENABLE = 2'd2,
        REQ_SWEEP  = 2'd3
    } ssc_req_t;

    typedef struct packed {
        ssc_req_t             req_type;
        logic [VALUE_W-1:0]   value;
    } ssc_item_t;

    typedef struct packed {
        logic                 status;
        logic                 drive;
        logic [DUTY_W-1:0]    duty;
        logic [ANGLE_W-1:0]   angle_now;
    } ssc_result_t;

endpackage

>>> hdl/ssc_duty_lut.sv
// Angle to PWM compare value table, built at elaboration from the pulse limits.
// Depends on ssc_pkg.
module ssc_duty_lut
    import ssc_pkg::*;
#(
    parameter int MIN_PULSE_US = 500,
    parameter int MAX_PULSE_US = 2500
)
(
    input  logic [ANGLE_W-1:0] angle,
    output logic [DUTY_W-1:0]  duty
);

    logic [DUTY_W-1:0] duty_tab [0:ANGLE_MAX];

    for (genvar g = 0; g <= ANGLE_MAX; g++)
    begin : g_entry
        localparam int unsigned PULSE =
            MIN_PULSE_US + (g * (MAX_PULSE_US - MIN_PULSE_US)) / ANGLE_MAX;
        localparam longint unsigned DUTY =
            (longint'(PULSE) * DUTY_FULL) / PWM_PERIOD_US;
        assign duty_tab[g] = DUTY_W'(DUTY);
    end

    // angle never exceeds ANGLE_MAX
    assign duty = duty_tab[angle];

endmodule

>>> hdl/ssc_core.sv
// Servo state registers and the combinational request evaluation.
// Depends on ssc_pkg and ssc_duty_lut.
module ssc_core
    import ssc_pkg::*;
#(
    parameter int MIN_PULSE_US = 500,
    parameter int MAX_PULSE_US = 2500
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  ssc_item_t          item,
    input  logic [SPEED_W-1:0] sweep_speed,
    output logic               res_valid,
    output ssc_result_t        result
);

    logic [ANGLE_W-1:0]   angle_reg, angle_next;
    logic                 enabled_reg, enabled_next;
    logic                 sweeping_reg, sweeping_next;
    logic                 dir_down_reg, dir_down_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W-1:0] interval;
    logic [ANGLE_W-1:0]   step_angle;
    logic                 step_dir_down;
    logic                 status;
    logic                 drive;
    logic [DUTY_W-1:0]    lut_duty;

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + ELAPSED_W'(1);
    assign interval    = ELAPSED_W'(SWEEP_BASE_MS - SWEEP_STEP_MS * int'(sweep_speed));

    // one degree step, turn round at either end
    always_comb
    begin
        step_angle    = angle_reg;
        step_dir_down = dir_down_reg;
        if (dir_down_reg)
        begin
            if (angle_reg <= ANGLE_W'(1))
            begin
                step_angle    = '0;
                step_dir_down = 1'b0;
            end
            else
            begin
                step_angle = angle_reg - ANGLE_W'(1);
            end
        end
        else
        begin
            if (angle_reg >= ANGLE_W'(ANGLE_MAX - 1))
            begin
                step_angle    = ANGLE_W'(ANGLE_MAX);
                step_dir_down = 1'b1;
            end
            else
            begin
                step_angle = angle_reg + ANGLE_W'(1);
            end
        end
    end

    always_comb
    begin
        angle_next    = angle_reg;
        enabled_next  = enabled_reg;
        sweeping_next = sweeping_reg;
        dir_down_next = dir_down_reg;
        elapsed_next  = elapsed_reg;
        res_valid     = 1'b0;
        status        = 1'b0;
        drive         = 1'b0;
        case (item.req_type)
            REQ_TICK:
            begin
                if (sweeping_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (enabled_reg && (elapsed_inc >= interval))
                    begin
                        elapsed_next  = '0;
                        angle_next    = step_angle;
                        dir_down_next = step_dir_down;
                        res_valid     = 1'b1;
                        drive         = 1'b1;
                    end
                end
            end
            REQ_ANGLE:
            begin
                res_valid = 1'b1;
                if (item.value > VALUE_W'(ANGLE_MAX))
                begin
                    status = 1'b1;
                end
                else
                begin
                    angle_next = ANGLE_W'(item.value);
                    drive      = enabled_reg;
                end
            end
            REQ_ENABLE:
            begin
                res_valid = 1'b1;
                if (item.value > VALUE_W'(1))
                begin
                    status = 1'b1;
                end
                else
                begin
                    enabled_next = item.value[0];
                    drive        = item.value[0];
                    if (!item.value[0])
                    begin
                        sweeping_next = 1'b0;
                    end
                end
            end
            REQ_SWEEP:
            begin
                res_valid = 1'b1;
                if (item.value > VALUE_W'(1))
                begin
                    status = 1'b1;
                end
                else
                begin
                    sweeping_next = item.value[0];
                    dir_down_next = 1'b0;
                    elapsed_next  = '0;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    ssc_duty_lut #(
        .MIN_PULSE_US (MIN_PULSE_US),
        .MAX_PULSE_US (MAX_PULSE_US)
    ) u_duty_lut (
        .angle (angle_next),
        .duty  (lut_duty)
    );

    always_comb
    begin
        result.status    = status;
        result.drive     = drive;
        result.duty      = drive ? lut_duty : '0;
        result.angle_now = angle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg    <= ANGLE_W'(ANGLE_HOME);
            enabled_reg  <= 1'b0;
            sweeping_reg <= 1'b0;
            dir_down_reg <= 1'b0;
            elapsed_reg  <= '0;
        end
        else if (item_valid)
        begin
            angle_reg    <= angle_next;
            enabled_reg  <= enabled_next;
            sweeping_reg <= sweeping_next;
            dir_down_reg <= dir_down_next;
            elapsed_reg  <= elapsed_next;
        end
    end

endmodule

>>> hdl/servo_sweep_controller_unit.sv
// Servo sweep controller: hobby-servo angle, enable and sweep control with PWM duty output.
// Depends on ssc_pkg, ssc_core and ssc_duty_lut.
//
// Usage:
//   Requests enter on the s_axis group: tuser carries the request kind
//   (tick, set angle, set enable, set sweep), tdata the 8-bit argument.
//   Send one tick request per millisecond to run the sweep.
//   Results leave on the m_axis group: tuser holds status and drive,
//   tdata holds the duty value and the current angle. Every command gives
//   one result; a tick gives one only when the sweep takes a step.
//   cfg_we/cfg_wdata write the sweep speed (1..10); other values are dropped.
//   Write it only while no request is in flight.
// Timing:
//   A request is held in the input register, is evaluated against
//   the servo state in one pass and lands in the result register at the next
//   edge once the result register is free; m_axis_tvalid then rises. One
//   request per cycle is sustained while the receiver does not stall;
//   the single evaluation pass through the duty table sets it.
//   When the receiver stalls, the result register holds, the input register
//   still takes one more request, then s_axis_tready drops.
// Reset: angle 90, disabled, no sweep, counting up, speed 5, both registers empty.
module servo_sweep_controller_unit
    import ssc_pkg::*;
#(
    parameter int MIN_PULSE_US = 500,
    parameter int MAX_PULSE_US = 2500
)
(
    input  logic               clk,
    input  logic               rst_n,
    // config
    input  logic               cfg_we,
    input  logic [SPEED_W-1:0] cfg_wdata,      // sweep_speed
    // request stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] value
    input  logic [1:0]         s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [23:0]        m_axis_tdata,   // [15:0] duty, [23:16] angle_now
    output logic [1:0]         m_axis_tuser    // [0] status, [1] drive
);

    logic               in_valid_reg;
    ssc_item_t          item_reg;
    logic               out_valid_reg;
    ssc_result_t        result_reg;
    logic [SPEED_W-1:0] speed_reg;

    logic               advance;
    logic               process;
    logic               res_valid;
    ssc_result_t        result;

    // result register frees up when empty or taken this cycle
    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // speed register: keep the old value on an out-of-range write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_W'(SPEED_RESET);
        end
        else if (cfg_we && (cfg_wdata >= SPEED_W'(SPEED_MIN))
                 && (cfg_wdata <= SPEED_W'(SPEED_MAX)))
        begin
            speed_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.req_type <= ssc_req_t'(s_axis_tuser);
            item_reg.value    <= s_axis_tdata;
        end
    end

    ssc_core #(
        .MIN_PULSE_US (MIN_PULSE_US),
        .MAX_PULSE_US (MAX_PULSE_US)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (process),
        .item        (item_reg),
        .sweep_speed (speed_reg),
        .res_valid   (res_valid),
        .result      (result)
    );

    // result register: load on advance; a silent tick leaves it empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= process && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && res_valid)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {result_reg.angle_now, result_reg.duty};
    assign m_axis_tuser  = {result_reg.drive, result_reg.status};

`ifndef SYNTHESIS
    // angle on the output never leaves the servo range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:16] <= 8'(ANGLE_MAX)))
    else $error("angle_now above range");

    // a rejected request must not drive the PWM
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
    else $error("error result with drive set");

    // duty is zero whenever drive is clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[15:0] == '0))
    else $error("nonzero duty without drive");

    // a stalled result stage must not let the core consume a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !process)
    else $error("request processed while result stalled");
`endif

endmodule
